>>> design/first_fit_block_allocator_defines.svh
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Assertion helpers for the allocator. They expect clk and rst_n in scope.

// The condition must hold at every clock edge outside reset.
`define FFBA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FFBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int ADDR_BITS_DEF    = 16;

  localparam int STATUS_W = 3;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_OK        = 3'd0;
  localparam status_t STATUS_NO_FIT    = 3'd1;
  localparam status_t STATUS_FULL      = 3'd2;
  localparam status_t STATUS_ZERO      = 3'd3;
  localparam status_t STATUS_NOT_FOUND = 3'd4;

  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  // Register map: one register, selected by paddr[2].
  localparam int  CFG_ADDR_W            = 3;
  localparam int  CFG_DATA_W            = 32;
  localparam logic REG_IDX_MEMORY_SIZE  = 1'b0;

  localparam logic [31:0] MEMORY_SIZE_RESET = 32'd65535;

endpackage

`default_nettype wire

>>> design/ffba_ram.sv
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

>>> design/first_fit_block_allocator.sv
// Channel   Ports                                             Direction
// input     in_valid, in_stall, in_action, in_request_size,   request in
//           in_free_address
// result    out_valid, out_stall, out_status, out_address     one result per request
// config    psel, penable, pwrite, paddr, pwdata, prdata,      memory_size at 0x0
//           pready
//
// A request of zero size goes straight to its result. Otherwise the scan reads one table entry
// per cycle, a split then moves every later entry up by one at the same pace, then two writes,
// and the result step loads the output register.
// Reset (rst_n, synchronous) leaves one free segment over the whole memory; no clearing pass.
// in_stall is high from acceptance until the result is loaded into the output register, which
// holds the transfer while out_stall is high.
`default_nettype none

`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator #(
  parameter int MAX_SEGMENTS = ffba_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = ffba_pkg::ADDR_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_action,
  input  wire logic [ADDR_BITS-1:0]              in_request_size,
  input  wire logic [ADDR_BITS-1:0]              in_free_address,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output ffba_pkg::status_t                      out_status,
  output logic      [ADDR_BITS-1:0]              out_address,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ffba_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [ffba_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [ffba_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  import ffba_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = 2 * ADDR_BITS + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_SPLIT  = 3'd3;
  localparam logic [2:0] S_SPLIT2 = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic                 action_r, action_nxt;
  logic [ADDR_BITS-1:0] req_r, req_nxt;
  logic [ADDR_BITS-1:0] fa_r, fa_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 init_r, init_nxt;
  logic [ADDR_BITS-1:0] memsize_r, memsize_nxt;
  logic [ADDR_BITS-1:0] hit_start_r, hit_start_nxt;
  logic [ADDR_BITS-1:0] hit_size_r, hit_size_nxt;
  status_t              status_r, status_nxt;
  logic [ADDR_BITS-1:0] result_addr_r, result_addr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [ADDR_BITS-1:0] out_address_r, out_address_nxt;

  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;
  logic [IW-1:0]        rd_addr;
  logic [EW-1:0]        rd_data;

  logic                 cfg_wr;
  logic [ADDR_BITS-1:0] cur_start;
  logic [ADDR_BITS-1:0] cur_size;
  logic                 cur_used;
  logic [CW-1:0]        idx_plus;
  logic                 last_entry;
  logic                 alloc_hit;
  logic                 free_hit;
  logic [ADDR_BITS-1:0] split_start;
  logic [ADDR_BITS-1:0] split_size;

  ffba_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_MEMORY_SIZE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_MEMORY_SIZE) ? CFG_DATA_W'(memsize_r) : '0;

  // Until entry 0 is first written it stands for the whole memory, free.
  always_comb begin
    if (init_r && (idx_r == '0)) begin
      cur_start = '0;
      cur_size  = memsize_r;
      cur_used  = 1'b0;
    end else begin
      cur_start = rd_data[EW-1 -: ADDR_BITS];
      cur_size  = rd_data[ADDR_BITS:1];
      cur_used  = rd_data[0];
    end
  end

  assign idx_plus    = CW'(idx_r) + CW'(1);
  assign last_entry  = idx_plus >= count_r;
  assign alloc_hit   = !cur_used && (cur_size >= req_r);
  assign free_hit    = cur_used && (cur_start == fa_r);
  assign split_start = hit_start_r + req_r;
  assign split_size  = hit_size_r - req_r;

  always_comb begin
    state_nxt       = state_r;
    action_nxt      = action_r;
    req_nxt         = req_r;
    fa_nxt          = fa_r;
    idx_nxt         = idx_r;
    k_nxt           = k_r;
    count_nxt       = count_r;
    init_nxt        = init_r;
    memsize_nxt     = memsize_r;
    hit_start_nxt   = hit_start_r;
    hit_size_nxt    = hit_size_r;
    status_nxt      = status_r;
    result_addr_nxt = result_addr_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_address_nxt = out_address_r;
    wr_en           = 1'b0;
    wr_addr         = idx_r;
    wr_data         = '0;
    rd_addr         = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_nxt = in_action;
          req_nxt    = in_request_size;
          fa_nxt     = in_free_address;
          if ((in_action == ACTION_ALLOC) && (in_request_size == '0)) begin
            status_nxt      = STATUS_ZERO;
            result_addr_nxt = '0;
            state_nxt       = S_FIN;
          end else begin
            idx_nxt   = '0;
            rd_addr   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if ((action_r == ACTION_ALLOC) && alloc_hit) begin
          if (cur_size == req_r) begin
            wr_en           = 1'b1;
            wr_data         = {cur_start, cur_size, 1'b1};
            status_nxt      = STATUS_OK;
            result_addr_nxt = cur_start;
            state_nxt       = S_FIN;
          end else if (count_r == CW'(MAX_SEGMENTS)) begin
            status_nxt      = STATUS_FULL;
            result_addr_nxt = '0;
            state_nxt       = S_FIN;
          end else begin
            hit_start_nxt = cur_start;
            hit_size_nxt  = cur_size;
            if (count_r > idx_plus) begin
              // Entries after the hit move up by one, highest first.
              k_nxt     = IW'(count_r - CW'(1));
              rd_addr   = IW'(count_r - CW'(1));
              state_nxt = S_SHIFT;
            end else begin
              state_nxt = S_SPLIT;
            end
          end
        end else if ((action_r == ACTION_FREE) && free_hit) begin
          wr_en           = 1'b1;
          wr_data         = {cur_start, cur_size, 1'b0};
          status_nxt      = STATUS_OK;
          result_addr_nxt = '0;
          state_nxt       = S_FIN;
        end else if (last_entry) begin
          status_nxt      = (action_r == ACTION_ALLOC) ? STATUS_NO_FIT : STATUS_NOT_FOUND;
          result_addr_nxt = '0;
          state_nxt       = S_FIN;
        end else begin
          idx_nxt = idx_r + IW'(1);
          rd_addr = idx_r + IW'(1);
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = k_r + IW'(1);
        wr_data = rd_data;
        if (CW'(k_r) > idx_plus) begin
          k_nxt   = k_r - IW'(1);
          rd_addr = k_r - IW'(1);
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r + IW'(1);
        wr_data   = {split_start, split_size, 1'b0};
        state_nxt = S_SPLIT2;
      end
      S_SPLIT2: begin
        wr_en           = 1'b1;
        wr_data         = {hit_start_r, req_r, 1'b1};
        count_nxt       = count_r + CW'(1);
        status_nxt      = STATUS_OK;
        result_addr_nxt = hit_start_r;
        state_nxt       = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_address_nxt = result_addr_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (wr_en && (wr_addr == '0)) begin
      init_nxt = 1'b0;
    end

    // A write of memory_size rebuilds the table as one free segment.
    if (cfg_wr) begin
      memsize_nxt = pwdata[ADDR_BITS-1:0];
      count_nxt   = CW'(1);
      init_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      init_r      <= 1'b1;
      memsize_r   <= MEMORY_SIZE_RESET[ADDR_BITS-1:0];
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      init_r      <= init_nxt;
      memsize_r   <= memsize_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r      <= action_nxt;
    req_r         <= req_nxt;
    fa_r          <= fa_nxt;
    idx_r         <= idx_nxt;
    k_r           <= k_nxt;
    hit_start_r   <= hit_start_nxt;
    hit_size_r    <= hit_size_nxt;
    status_r      <= status_nxt;
    result_addr_r <= result_addr_nxt;
    out_status_r  <= out_status_nxt;
    out_address_r <= out_address_nxt;
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_address = out_address_r;

  `FFBA_ASSERT_ALWAYS(a_count_range, (count_r != '0) && (count_r <= CW'(MAX_SEGMENTS)), "segment count out of range")
  `FFBA_ASSERT_SAME(a_result_from_fin, $rose(out_valid_r), $past(state_r) == S_FIN, "result raised outside the final step")
  `FFBA_ASSERT_NEXT(a_split_grows, (state_r == S_SPLIT2) && !cfg_wr, count_r == $past(count_r) + CW'(1), "split did not add a segment")

endmodule

`default_nettype wire
